/* hdl/rws_pkg.sv */
// Shared types and constants for the reinforced walk step block.
// Used by the channel interfaces, the site memory, the remainder unit,
// the controller and the top level.
package rws_pkg;

	// Lattice and walker sizes.
	localparam int unsigned SITES   = 65536;
	localparam int unsigned WALKERS = 8;
	localparam int unsigned ADDR_W  = (SITES > 1) ? $clog2(SITES) : 1;

	// Field widths fixed by the item formats.
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned WALKER_W = 3;
	localparam int unsigned POS_W    = 16;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned DIR_W    = 2;
	localparam int unsigned MASK_W   = 8;
	localparam int unsigned OWN_W    = 4;

	// Arithmetic widths: modulus, weights, cumulative sums and the product.
	localparam int unsigned N_W    = 17;
	localparam int unsigned WT_W   = 17;
	localparam int unsigned CUM_W  = WT_W + 2;
	localparam int unsigned PROD_W = CUM_W + FRAC_W;

	// Largest usable modulus: the position field and the memory both bound it.
	localparam int unsigned N_MAX_INT = (SITES < 65536) ? SITES : 65536;
	localparam logic [N_W-1:0] N_MAX = N_W'(N_MAX_INT);
	localparam logic [N_W-1:0] N_MIN = N_W'(2);

	// Configuration port.
	localparam int unsigned CFG_W = 17;
	localparam int unsigned CFG_INDEX_W = 2;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	localparam cfg_index_t REG_GRID_LENGTH = 2'd0;
	localparam cfg_index_t REG_SITE_COUNT  = 2'd1;
	localparam cfg_index_t REG_BETA_WEIGHT = 2'd2;

	// Item kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_PLACE = 2'd0,
		KIND_STEP  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	// Move directions, in the order the neighbours are examined.
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
	localparam logic [DIR_W-1:0] DIR_UP    = 2'd1;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

	// Configuration as seen by the controller.
	typedef struct packed {
		logic [POS_W-1:0] grid_length;
		logic [N_W-1:0]   modulus;
		logic [FRAC_W-1:0] beta_weight;
	} cfg_t;

	// One result transaction.
	typedef struct packed {
		logic [WALKER_W-1:0] walker;
		logic [POS_W-1:0]    new_position;
		logic [DIR_W-1:0]    direction;
		logic [MASK_W-1:0]   touched_mask;
		logic                claimed;
	} res_t;

	// Site memory ports.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [OWN_W-1:0]  data;
	} mem_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} mem_rd_t;

	// Remainder unit request and response.
	typedef struct packed {
		logic             start;
		logic [POS_W-1:0] dividend;
		logic [N_W-1:0]   divisor;
	} rem_req_t;

	typedef struct packed {
		logic             done;
		logic [POS_W-1:0] remainder;
	} rem_rsp_t;

endpackage

/* hdl/rws_in_if.sv */
// Input channel of the reinforced walk step block: valid, ready and one item.
// Depends on rws_pkg for the field widths.
interface rws_in_if;
	import rws_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [WALKER_W-1:0] walker;
	logic [POS_W-1:0]    start_position;
	logic [FRAC_W-1:0]   rand_fraction;

	modport source (output valid, kind, walker, start_position, rand_fraction, input ready);
	modport sink (input valid, kind, walker, start_position, rand_fraction, output ready);
endinterface

/* hdl/rws_out_if.sv */
// Result channel of the reinforced walk step block: valid, ready and one result.
// Depends on rws_pkg for the field widths.
interface rws_out_if;
	import rws_pkg::*;

	logic                valid;
	logic                ready;
	logic [WALKER_W-1:0] out_walker;
	logic [POS_W-1:0]    new_position;
	logic [DIR_W-1:0]    direction;
	logic [MASK_W-1:0]   touched_mask;
	logic                claimed;

	modport source (output valid, out_walker, new_position, direction, touched_mask, claimed,
		input ready);
	modport sink (input valid, out_walker, new_position, direction, touched_mask, claimed,
		output ready);
endinterface

/* hdl/rws_site_mem.sv */
// Site owner memory: one write port and one read port, registered read data.
// Depends on rws_pkg for the depth and the port structs.
module rws_site_mem (
	input  logic                          clk,
	input  rws_pkg::mem_wr_t              wr,
	input  rws_pkg::mem_rd_t              rd,
	output logic [rws_pkg::OWN_W-1:0]     rdata
);
	import rws_pkg::*;

	logic [OWN_W-1:0] mem [SITES];
	logic [OWN_W-1:0] rdata_q;

	// Write and read ports; the read data is registered and appears in the cycle after the request.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata_q <= mem[rd.addr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* hdl/rws_rem.sv */
// Bit-serial remainder unit: dividend mod divisor, one quotient bit per cycle.
// Depends on rws_pkg for widths and the request and response structs.
module rws_rem (
	input  logic              clk,
	input  logic              arst_n,
	input  rws_pkg::rem_req_t req,
	output rws_pkg::rem_rsp_t rsp
);
	import rws_pkg::*;

	localparam int unsigned CNT_W = $clog2(POS_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [POS_W-1:0] rem_q;
	logic [POS_W-1:0] dvd_q;
	logic [N_W-1:0]   dvs_q;
	logic [N_W-1:0]   trial;
	logic             fits;

	// Bring down the next dividend bit and try to subtract the divisor.
	assign trial = {rem_q, dvd_q[POS_W-1]};
	assign fits  = (trial >= dvs_q);

	// Control: a dividend already below the divisor finishes at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if ({1'b0, req.dividend} < req.divisor) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(POS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and shifting dividend.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvs_q <= req.divisor;
			dvd_q <= req.dividend;
			if ({1'b0, req.dividend} < req.divisor) begin
				rem_q <= req.dividend;
			end else begin
				rem_q <= '0;
			end
		end else if (busy_q) begin
			dvd_q <= {dvd_q[POS_W-2:0], 1'b0};
			if (fits) begin
				rem_q <= POS_W'(trial - dvs_q);
			end else begin
				rem_q <= trial[POS_W-1:0];
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;
endmodule

/* hdl/rws_ctrl.sv */
// Walk controller: sequencer that reads neighbour owners from the site memory,
// weighs them, picks a move, claims the site and holds the result register.
// Depends on rws_pkg, the channel interfaces, rws_site_mem and rws_rem.
module rws_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  rws_pkg::cfg_t cfg,
	rws_in_if.sink        items,
	rws_out_if.source     results
);
	import rws_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_POS_MOD,
		S_G_MOD,
		S_NEIGH,
		S_READ,
		S_MUL,
		S_PICK,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic               clr_item_q;
	logic               out_valid_q;
	logic [POS_W-1:0]   pos_q [WALKERS];

	logic                place_q;
	logic [WALKER_W-1:0] walker_q;
	logic [FRAC_W-1:0]   rand_q;
	logic [POS_W-1:0]    x_q;
	logic [POS_W-1:0]    g_q;
	logic [POS_W-1:0]    nb_q [4];
	logic [OWN_W-1:0]    own_q [4];
	logic [CUM_W-1:0]    cum_q [4];
	logic [MASK_W-1:0]   mask_q;
	logic [2:0]          rd_cnt_q;
	logic [PROD_W-1:0]   prod_q;
	res_t                res_q;
	res_t                out_q;

	mem_wr_t          mem_wr;
	mem_rd_t          mem_rd;
	logic [OWN_W-1:0] mem_rdata;
	rem_req_t         rem_req;
	rem_rsp_t         rem_rsp;

	logic                accept;
	logic                walker_ok;
	logic                load_out;
	logic [OWN_W-1:0]    own_tag;
	logic [N_W-1:0]      n_m1;
	logic [N_W-1:0]      sum_up;
	logic [POS_W-1:0]    nb_calc [4];
	logic [1:0]          cap_idx;
	logic [CUM_W-1:0]    prev_cum;
	logic [WT_W-1:0]     cap_wt;
	logic [MASK_W-1:0]   cap_mask;
	logic [DIR_W-1:0]    pick_dir;
	logic [POS_W-1:0]    pick_pos;
	logic                pick_free;

	rws_site_mem u_mem (
		.clk   (clk),
		.wr    (mem_wr),
		.rd    (mem_rd),
		.rdata (mem_rdata)
	);

	rws_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// Input handshake: one item at a time, taken only from the idle state.
	assign items.ready = (state_q == S_IDLE);
	assign accept      = items.valid && (state_q == S_IDLE);
	assign walker_ok   = ({1'b0, items.walker} < (WALKER_W + 1)'(WALKERS));
	assign load_out    = (state_q == S_DONE) && (!out_valid_q || results.ready);
	assign own_tag     = OWN_W'(walker_q) + 1'b1;

	// Remainder requests: position (or start site) first, then the row length.
	always_comb begin
		rem_req.start    = 1'b0;
		rem_req.dividend = '0;
		rem_req.divisor  = cfg.modulus;
		if (accept && walker_ok && items.kind == KIND_PLACE) begin
			rem_req.start    = 1'b1;
			rem_req.dividend = items.start_position;
		end else if (accept && walker_ok && items.kind == KIND_STEP) begin
			rem_req.start    = 1'b1;
			rem_req.dividend = pos_q[items.walker];
		end else if (state_q == S_POS_MOD && rem_rsp.done && !place_q) begin
			rem_req.start    = 1'b1;
			rem_req.dividend = cfg.grid_length;
		end
	end

	// Neighbour sites with helical wrap: left, up, right, down.
	always_comb begin
		n_m1       = cfg.modulus - 1'b1;
		sum_up     = {1'b0, x_q} + {1'b0, g_q};
		nb_calc[0] = (x_q == '0) ? POS_W'(n_m1) : x_q - 1'b1;
		nb_calc[1] = (sum_up >= cfg.modulus) ? POS_W'(sum_up - cfg.modulus) : POS_W'(sum_up);
		nb_calc[2] = ({1'b0, x_q} == n_m1) ? '0 : x_q + 1'b1;
		nb_calc[3] = (x_q >= g_q) ? x_q - g_q
			: POS_W'({1'b0, x_q} + cfg.modulus - {1'b0, g_q});
	end

	// Owner capture during the read sweep: weight and touched-walker mask.
	always_comb begin
		cap_idx  = 2'(rd_cnt_q - 3'd1);
		prev_cum = (cap_idx == 2'd0) ? '0 : cum_q[cap_idx - 2'd1];
		cap_wt   = (mem_rdata == '0) ? {1'b0, cfg.beta_weight}
			: WT_W'(17'h10000 - {1'b0, cfg.beta_weight});
		cap_mask = mask_q;
		if (mem_rdata != '0 && mem_rdata != own_tag) begin
			cap_mask[3'(mem_rdata - 1'b1)] = 1'b1;
		end
	end

	// Move decision: first direction whose cumulative weight covers the draw.
	always_comb begin
		if (prod_q <= {cum_q[0], FRAC_W'(0)}) begin
			pick_dir = DIR_LEFT;
		end else if (prod_q <= {cum_q[1], FRAC_W'(0)}) begin
			pick_dir = DIR_UP;
		end else if (prod_q <= {cum_q[2], FRAC_W'(0)}) begin
			pick_dir = DIR_RIGHT;
		end else begin
			pick_dir = DIR_DOWN;
		end
		pick_pos  = nb_q[pick_dir];
		pick_free = (own_q[pick_dir] == '0);
	end

	// Site memory accesses: clearing sweep, neighbour reads and the claim write.
	always_comb begin
		mem_wr.en   = 1'b0;
		mem_wr.addr = '0;
		mem_wr.data = '0;
		mem_rd.en   = 1'b0;
		mem_rd.addr = '0;
		if (state_q == S_CLEAR) begin
			mem_wr.en   = 1'b1;
			mem_wr.addr = clr_addr_q;
		end else if (state_q == S_PICK) begin
			mem_wr.en   = pick_free;
			mem_wr.addr = ADDR_W'(pick_pos);
			mem_wr.data = own_tag;
		end
		if (state_q == S_READ && !rd_cnt_q[2]) begin
			mem_rd.en   = 1'b1;
			mem_rd.addr = ADDR_W'(nb_q[rd_cnt_q[1:0]]);
		end
	end

	// Sequencer, walker positions and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			clr_item_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < WALKERS; i++) begin
				pos_q[i] <= '0;
			end
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(SITES - 1)) begin
						state_q <= clr_item_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (items.kind == KIND_CLEAR) begin
							state_q    <= S_CLEAR;
							clr_addr_q <= '0;
							clr_item_q <= 1'b1;
						end else if (walker_ok &&
							(items.kind == KIND_PLACE || items.kind == KIND_STEP)) begin
							state_q <= S_POS_MOD;
						end
					end
				end
				S_POS_MOD: begin
					if (rem_rsp.done) begin
						if (place_q) begin
							pos_q[walker_q] <= rem_rsp.remainder;
							state_q         <= S_DONE;
						end else begin
							state_q <= S_G_MOD;
						end
					end
				end
				S_G_MOD: begin
					if (rem_rsp.done) begin
						state_q <= S_NEIGH;
					end
				end
				S_NEIGH: begin
					state_q <= S_READ;
				end
				S_READ: begin
					if (rd_cnt_q[2]) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					pos_q[walker_q] <= pick_pos;
					state_q         <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			place_q  <= (items.kind == KIND_PLACE);
			walker_q <= items.walker;
			rand_q   <= items.rand_fraction;
			res_q    <= '0;
		end
		if (state_q == S_POS_MOD && rem_rsp.done) begin
			x_q <= rem_rsp.remainder;
			if (place_q) begin
				res_q.walker       <= walker_q;
				res_q.new_position <= rem_rsp.remainder;
			end
		end
		if (state_q == S_G_MOD && rem_rsp.done) begin
			g_q <= rem_rsp.remainder;
		end
		if (state_q == S_NEIGH) begin
			for (int i = 0; i < 4; i++) begin
				nb_q[i] <= nb_calc[i];
			end
			rd_cnt_q <= '0;
			mask_q   <= '0;
		end
		if (state_q == S_READ) begin
			rd_cnt_q <= rd_cnt_q + 1'b1;
			if (rd_cnt_q != '0) begin
				own_q[cap_idx] <= mem_rdata;
				cum_q[cap_idx] <= prev_cum + CUM_W'(cap_wt);
				mask_q         <= cap_mask;
			end
		end
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(rand_q) * PROD_W'(cum_q[3]);
		end
		if (state_q == S_PICK) begin
			res_q.walker       <= walker_q;
			res_q.new_position <= pick_pos;
			res_q.direction    <= pick_dir;
			res_q.touched_mask <= mask_q;
			res_q.claimed      <= pick_free;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	// Result channel.
	assign results.valid        = out_valid_q;
	assign results.out_walker   = out_q.walker;
	assign results.new_position = out_q.new_position;
	assign results.direction    = out_q.direction;
	assign results.touched_mask = out_q.touched_mask;
	assign results.claimed      = out_q.claimed;
endmodule

/* hdl/reinforced_walk_step.sv */
// Reinforced walk step: moves walkers on a helically wrapped lattice whose site
// owners live in one synchronous memory. After reset the block sweeps the whole
// site memory (SITES entries, 65536 as built) before it takes the first item; a
// clear item runs the same sweep and then returns its result. A place item
// reduces its start site and stores it. A step item reduces its stored position
// and the row length, then makes four neighbour reads through the single read
// port of the site memory, one multiply, the decision with the claim write, and
// the result hand-off. A start site, stored position or row length that is not
// below the current modulus is reduced bit by bit in the bit-serial remainder
// unit. Only one item is in work at a time; a finished result waits in an output
// register while the next item is taken.
module reinforced_walk_step (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  rws_pkg::cfg_index_t         cfg_index,
	input  logic [rws_pkg::CFG_W-1:0]   cfg_data,
	rws_in_if.sink                      items,
	rws_out_if.source                   results
);
	import rws_pkg::*;

	logic [POS_W-1:0]  grid_length_q;
	logic [N_W-1:0]    site_count_q;
	logic [FRAC_W-1:0] beta_weight_q;
	cfg_t              cfg;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_length_q <= POS_W'(256);
			site_count_q  <= N_W'(65536);
			beta_weight_q <= FRAC_W'(19661);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_GRID_LENGTH: grid_length_q <= cfg_data[POS_W-1:0];
				REG_SITE_COUNT:  site_count_q  <= cfg_data[N_W-1:0];
				REG_BETA_WEIGHT: beta_weight_q <= cfg_data[FRAC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Wrap modulus: site count held between two and the usable maximum.
	always_comb begin
		cfg.grid_length = grid_length_q;
		cfg.beta_weight = beta_weight_q;
		if (site_count_q > N_MAX) begin
			cfg.modulus = N_MAX;
		end else if (site_count_q < N_MIN) begin
			cfg.modulus = N_MIN;
		end else begin
			cfg.modulus = site_count_q;
		end
	end

	rws_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.items   (items),
		.results (results)
	);
endmodule
